### hw/rtl/prleq_pkg.sv
// shared types and constants of the priced rate-limited egress queue
`default_nettype none
package prleq_pkg;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_ARRIVAL = 1'b0,
        CMD_TICK    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_BUFFER_SPACE = 2'd0,
        CFG_LINK_RATE    = 2'd1,
        CFG_TARGET_UTIL  = 2'd2,
        CFG_PRICE_GAIN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_STEP  = 3'd0,
        OP_DELTA = 3'd1,
        OP_LU    = 3'd2,
        OP_LR    = 3'd3,
        OP_MQ    = 3'd4,
        OP_MD    = 3'd5,
        OP_BU    = 3'd6,
        OP_DLY   = 3'd7
    } t_op;

    localparam logic [62:0] PRICE_FLOOR = 63'd281;
    localparam logic [62:0] PRICE_START = 63'd28147497671;
    localparam logic [62:0] PRICE_MAX   = {63{1'b1}};
    localparam logic [23:0] RST_BUFFER_SPACE = 24'd0;
    localparam logic [23:0] RST_LINK_RATE    = 24'd256;
    localparam logic [16:0] RST_TARGET_UTIL  = 17'd58982;
    localparam logic [16:0] RST_PRICE_GAIN   = 17'd197;

    // request to and response from the shared multiply-divide unit
    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_md_rsp;

endpackage
`default_nettype wire

### hw/rtl/prleq_ram.sv
// generic single write port ram with registered read
`default_nettype none
module prleq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/prleq_muldiv.sv
// iterative floor(x * y / z) unit, shift-add multiply then restoring divide
`default_nettype none
module prleq_muldiv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire prleq_pkg::t_md_req i_req,
    output prleq_pkg::t_md_rsp      o_rsp
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate      r_state, n_state;
    logic [127:0] r_acc, n_acc;
    logic [127:0] r_mx, n_mx;
    logic [63:0]  r_my, n_my;
    logic [63:0]  r_z, n_z;
    logic [63:0]  r_rem, n_rem;
    logic [63:0]  r_q, n_q;
    logic [5:0]   r_cnt, n_cnt;
    logic         r_done, n_done;
    logic [64:0]  w_trial;

    assign w_trial = {r_rem, r_acc[63]};

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mx    = r_mx;
        n_my    = r_my;
        n_z     = r_z;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_acc   = '0;
                    n_mx    = {64'd0, i_req.x};
                    n_my    = i_req.y;
                    n_z     = i_req.z;
                    n_state = U_MUL;
                end
            end
            U_MUL: begin
                if (r_my == '0) begin
                    if (r_acc[127:64] >= r_z) begin
                        n_q     = '1;
                        n_done  = 1'b1;
                        n_state = U_IDLE;
                    end else begin
                        n_rem   = r_acc[127:64];
                        n_cnt   = 6'd63;
                        n_q     = '0;
                        n_state = U_DIV;
                    end
                end else begin
                    if (r_my[0]) begin
                        n_acc = r_acc + r_mx;
                    end
                    n_mx = {r_mx[126:0], 1'b0};
                    n_my = {1'b0, r_my[63:1]};
                end
            end
            U_DIV: begin
                if (w_trial >= {1'b0, r_z}) begin
                    n_rem = 64'(w_trial - {1'b0, r_z});
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = w_trial[63:0];
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_acc = {r_acc[126:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_acc <= n_acc;
        r_mx  <= n_mx;
        r_my  <= n_my;
        r_z   <= n_z;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule
`default_nettype wire

### hw/rtl/priced_rate_limited_egress_queue.sv
// top level: egress queue sequencer, entry rams and shared multiply-divide unit
//
//   channel  dir  handshake                   contents
//   input    in   i_s_tvalid / o_s_tready     tuser command, tdata amount, quality
//   result   out  o_m_tvalid / i_m_tready     tuser kind, tlast, tdata statistics
//   config   in   i_cfg_wen                   index i_cfg_idx, data i_cfg_wdata
//
// an arrival is taken only in idle with the result register empty
// a tick runs 2 price ops when the target load is nonzero, a read, calc and
// accumulate step per drained segment, 5 statistic ops and, when the link rate
// is nonzero, a read and calc step per queued entry plus one op for each entry
// without a delay yet; reset is synchronous; queue entries are never read before
// they are written; a stalled result register holds the sequencer in place
`default_nettype none
module priced_rate_limited_egress_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [39:0]   i_s_tdata,   // packet_amount, packet_quality, pad
    input  wire logic          i_s_tuser,   // command
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic      [247:0]  o_m_tdata,   // amount, dropped_amount, segment_delay,
                                            // price_now, link_use, loss_ratio,
                                            // mean_delay, mean_quality, buffer_use
    output logic      [1:0]    o_m_tuser,   // result_kind
    output logic               o_m_tlast,   // last_of_run
    input  wire logic          i_cfg_wen,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [23:0]   i_cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_C = (CW+1)'(QUEUE_DEPTH);
    localparam logic [62:0] PRICE_MAX_F = prleq_pkg::PRICE_MAX;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_OP      = 9'b000000010,
        S_OPW     = 9'b000000100,
        S_DR_RD   = 9'b000001000,
        S_DR_CALC = 9'b000010000,
        S_DR_ACC  = 9'b000100000,
        S_SUM     = 9'b001000000,
        S_DW_RD   = 9'b010000000,
        S_DW_CALC = 9'b100000000
    } t_state;

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic [57:0] add_sat58(logic [57:0] a, logic [57:0] b);
        logic [58:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[58] ? {58{1'b1}} : s[57:0];
    endfunction

    function automatic logic [AW-1:0] wrap(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= DEPTH_C) begin
            s = s - DEPTH_C;
        end
        return s[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    prleq_pkg::t_op     r_op, n_op;
    logic [23:0]        r_bs, r_lr;
    logic [16:0]        r_tu, r_gain;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [25:0]        r_buf, n_buf;
    logic [31:0]        r_demand, n_demand;
    logic [62:0]        r_price, n_price;
    logic [31:0]        r_lost, n_lost;
    logic [31:0]        r_arr, n_arr;
    logic [47:0]        r_qws, n_qws;
    logic [57:0]        r_dws, n_dws;
    logic [63:0]        r_step, n_step;
    logic [23:0]        r_sent, n_sent;
    logic [38:0]        r_pq, n_pq;
    logic [55:0]        r_pd, n_pd;
    logic [16:0]        r_lu, n_lu, r_lr_s, n_lr_s;
    logic [31:0]        r_md, n_md;
    logic [14:0]        r_mq, n_mq;
    logic [23:0]        r_bu, n_bu;
    logic [CW-1:0]      r_wi, n_wi;
    logic [26:0]        r_run, n_run;

    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_okind, n_okind;
    logic [23:0]        r_oamt, n_oamt, r_odrop, n_odrop, r_obu, n_obu;
    logic [31:0]        r_osdel, n_osdel, r_omd, n_omd;
    logic [62:0]        r_oprice, n_oprice;
    logic [16:0]        r_olu, n_olu, r_olr, n_olr;
    logic [14:0]        r_omq, n_omq;
    logic               r_olast, n_olast;

    prleq_pkg::t_md_req w_req;
    prleq_pkg::t_md_rsp w_rsp;

    logic               w_we_amt, w_we_qual, w_we_dly;
    logic [AW-1:0]      w_waddr, w_raddr, w_tail, w_walk;
    logic [23:0]        w_wamt, w_ramt;
    logic [14:0]        w_rqual;
    logic [31:0]        w_wdly, w_rdly;

    logic [40:0]        w_load;
    logic [47:0]        w_want, w_mag;
    logic [27:0]        w_lr10;
    logic               w_accept;
    logic [23:0]        w_in_amt;
    logic [14:0]        w_in_qual;
    logic [24:0]        w_cap;
    logic [26:0]        w_fit;
    logic [23:0]        w_take, w_drop;
    logic               w_push;
    logic [24:0]        w_dsum;
    logic               w_whole;
    logic [23:0]        w_part;
    logic [62:0]        w_room;

    assign w_in_amt  = i_s_tdata[23:0];
    assign w_in_qual = i_s_tdata[38:24];
    assign o_s_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_accept  = i_s_tvalid && o_s_tready;

    assign w_load = r_tu * r_lr;
    assign w_want = {r_demand, 16'd0};
    assign w_mag  = (w_want >= 48'(w_load)) ? w_want - 48'(w_load) : 48'(w_load) - w_want;
    assign w_lr10 = 28'(r_lr) * 28'd10;
    assign w_tail = wrap(r_head, r_count);
    assign w_walk = wrap(r_head, r_wi);
    assign w_room = PRICE_MAX_F - r_price;

    // arrival verdict
    always_comb begin
        w_cap  = {1'b0, r_bs} + {1'b0, r_lr};
        w_fit  = {1'b0, r_buf} + {3'd0, w_in_amt};
        w_take = '0;
        w_drop = w_in_amt;
        w_push = 1'b0;
        if ({1'b0, r_count} >= DEPTH_C) begin
            w_push = 1'b0;
        end else if (w_fit <= {2'd0, w_cap}) begin
            w_take = w_in_amt;
            w_drop = '0;
            w_push = 1'b1;
        end else if (r_buf < {1'b0, w_cap}) begin
            w_take = 24'({1'b0, w_cap} - r_buf);
            w_drop = w_in_amt - w_take;
            w_push = 1'b1;
        end
    end

    // drain segment
    assign w_dsum  = {1'b0, r_sent} + {1'b0, w_ramt};
    assign w_whole = w_dsum <= {1'b0, r_lr};
    assign w_part  = w_whole ? w_ramt : r_lr - r_sent;

    // operands of the shared unit
    always_comb begin
        w_req.start = (r_state == S_OP);
        w_req.x = '0;
        w_req.y = '0;
        w_req.z = '0;
        unique case (r_op)
            prleq_pkg::OP_STEP: begin
                w_req.x = 64'(r_price);
                w_req.y = 64'(r_gain);
                w_req.z = 64'd65536;
            end
            prleq_pkg::OP_DELTA: begin
                w_req.x = r_step;
                w_req.y = 64'(w_mag);
                w_req.z = 64'(w_load);
            end
            prleq_pkg::OP_LU: begin
                w_req.x = 64'(r_sent);
                w_req.y = 64'd65536;
                w_req.z = 64'(r_lr);
            end
            prleq_pkg::OP_LR: begin
                w_req.x = 64'(r_lost);
                w_req.y = 64'd65536;
                w_req.z = 64'(r_arr);
            end
            prleq_pkg::OP_MQ: begin
                w_req.x = 64'(r_qws);
                w_req.y = 64'd1;
                w_req.z = 64'(r_arr);
            end
            prleq_pkg::OP_MD: begin
                w_req.x = 64'(r_dws);
                w_req.y = 64'd1;
                w_req.z = (r_arr > r_lost) ? 64'(r_arr - r_lost) : 64'd0;
            end
            prleq_pkg::OP_BU: begin
                w_req.x = 64'(r_buf);
                w_req.y = 64'd65536;
                w_req.z = 64'(r_bs);
            end
            prleq_pkg::OP_DLY: begin
                w_req.x = 64'(r_run);
                w_req.y = 64'd16777216;
                w_req.z = 64'(w_lr10);
            end
            default: w_req.x = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_head   = r_head;
        n_count  = r_count;
        n_buf    = r_buf;
        n_demand = r_demand;
        n_price  = r_price;
        n_lost   = r_lost;
        n_arr    = r_arr;
        n_qws    = r_qws;
        n_dws    = r_dws;
        n_step   = r_step;
        n_sent   = r_sent;
        n_pq     = r_pq;
        n_pd     = r_pd;
        n_lu     = r_lu;
        n_lr_s   = r_lr_s;
        n_md     = r_md;
        n_mq     = r_mq;
        n_bu     = r_bu;
        n_wi     = r_wi;
        n_run    = r_run;
        n_ovalid = r_ovalid && !i_m_tready;
        n_okind  = r_okind;
        n_oamt   = r_oamt;
        n_odrop  = r_odrop;
        n_osdel  = r_osdel;
        n_oprice = r_oprice;
        n_olu    = r_olu;
        n_olr    = r_olr;
        n_omd    = r_omd;
        n_omq    = r_omq;
        n_obu    = r_obu;
        n_olast  = r_olast;
        w_we_amt  = 1'b0;
        w_we_qual = 1'b0;
        w_we_dly  = 1'b0;
        w_waddr   = w_tail;
        w_wamt    = w_take;
        w_wdly    = '0;
        w_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == prleq_pkg::CMD_ARRIVAL) begin
                        if (w_push) begin
                            w_we_amt  = 1'b1;
                            w_we_qual = 1'b1;
                            w_we_dly  = 1'b1;
                            n_count   = r_count + 1'b1;
                            n_buf     = r_buf + 26'(w_take);
                        end
                        n_lost   = add_sat32(r_lost, 32'(w_drop));
                        n_qws    = add_sat48(r_qws, 48'({w_drop, 12'd0}));
                        n_demand = add_sat32(r_demand, 32'(w_in_amt));
                        n_arr    = add_sat32(r_arr, 32'(w_in_amt));
                        n_ovalid = 1'b1;
                        n_okind  = prleq_pkg::KIND_VERDICT;
                        n_oamt   = w_take;
                        n_odrop  = w_drop;
                        n_osdel  = '0;
                        n_oprice = r_price;
                        n_olu    = '0;
                        n_olr    = '0;
                        n_omd    = '0;
                        n_omq    = '0;
                        n_obu    = '0;
                        n_olast  = 1'b1;
                    end else begin
                        n_sent = '0;
                        if (w_load != '0) begin
                            n_op    = prleq_pkg::OP_STEP;
                            n_state = S_OP;
                        end else begin
                            n_state = S_DR_RD;
                        end
                    end
                end
            end
            S_OP: begin
                n_state = S_OPW;
            end
            S_OPW: begin
                if (w_rsp.done) begin
                    n_state = S_OP;
                    unique case (r_op)
                        prleq_pkg::OP_STEP: begin
                            n_step = w_rsp.q;
                            n_op   = prleq_pkg::OP_DELTA;
                        end
                        prleq_pkg::OP_DELTA: begin
                            if (w_want >= 48'(w_load)) begin
                                n_price = (w_rsp.q > 64'(w_room)) ? PRICE_MAX_F
                                        : r_price + w_rsp.q[62:0];
                            end else begin
                                n_price = (w_rsp.q >= 64'(r_price)) ? 63'd0
                                        : r_price - w_rsp.q[62:0];
                            end
                            if (n_price < prleq_pkg::PRICE_FLOOR) begin
                                n_price = prleq_pkg::PRICE_FLOOR;
                            end
                            n_state = S_DR_RD;
                        end
                        prleq_pkg::OP_LU: begin
                            n_lu = (r_lr != '0) ? w_rsp.q[16:0] : 17'd0;
                            n_op = prleq_pkg::OP_LR;
                        end
                        prleq_pkg::OP_LR: begin
                            n_lr_s = (r_arr == '0) ? 17'd0
                                   : (w_rsp.q > 64'd65536) ? 17'd65536 : w_rsp.q[16:0];
                            n_op   = prleq_pkg::OP_MQ;
                        end
                        prleq_pkg::OP_MQ: begin
                            n_mq = (r_arr == '0) ? 15'd0
                                 : (w_rsp.q > 64'h7FFF) ? 15'h7FFF : w_rsp.q[14:0];
                            n_op = prleq_pkg::OP_MD;
                        end
                        prleq_pkg::OP_MD: begin
                            n_md = (r_arr <= r_lost) ? 32'd0
                                 : (w_rsp.q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                 : w_rsp.q[31:0];
                            n_op = prleq_pkg::OP_BU;
                        end
                        prleq_pkg::OP_BU: begin
                            if (r_bs != '0) begin
                                n_bu = (w_rsp.q > 64'hFF_FFFF) ? 24'hFF_FFFF : w_rsp.q[23:0];
                            end else begin
                                n_bu = (r_buf != '0) ? 24'hFF_FFFF : 24'd0;
                            end
                            n_state = S_SUM;
                        end
                        prleq_pkg::OP_DLY: begin
                            w_raddr  = w_walk;
                            w_waddr  = w_walk;
                            w_we_dly = 1'b1;
                            w_wdly   = (w_rsp.q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                     : w_rsp.q[31:0];
                            n_wi     = r_wi + 1'b1;
                            n_state  = S_DW_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else if (r_op == prleq_pkg::OP_DLY) begin
                    w_raddr = w_walk;
                end
            end
            S_DR_RD: begin
                if (r_count == '0 || r_sent >= r_lr) begin
                    n_op    = prleq_pkg::OP_LU;
                    n_state = S_OP;
                end else begin
                    n_state = S_DR_CALC;
                end
            end
            S_DR_CALC: begin
                if (!r_ovalid) begin
                    n_pq     = w_part * w_rqual;
                    n_pd     = w_part * w_rdly;
                    n_buf    = r_buf - 26'(w_part);
                    n_sent   = r_sent + w_part;
                    n_ovalid = 1'b1;
                    n_okind  = prleq_pkg::KIND_SEGMENT;
                    n_oamt   = w_part;
                    n_odrop  = '0;
                    n_osdel  = w_rdly;
                    n_oprice = r_price;
                    n_olu    = '0;
                    n_olr    = '0;
                    n_omd    = '0;
                    n_omq    = '0;
                    n_obu    = '0;
                    n_olast  = 1'b0;
                    if (w_whole) begin
                        n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end else begin
                        w_we_amt = 1'b1;
                        w_waddr  = r_head;
                        w_wamt   = w_ramt - w_part;
                    end
                    n_state = S_DR_ACC;
                end
            end
            S_DR_ACC: begin
                n_qws   = add_sat48(r_qws, 48'(r_pq));
                n_dws   = add_sat58(r_dws, 58'(r_pd));
                n_state = S_DR_RD;
            end
            S_SUM: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_okind  = prleq_pkg::KIND_SUMMARY;
                    n_oamt   = '0;
                    n_odrop  = '0;
                    n_osdel  = '0;
                    n_oprice = r_price;
                    n_olu    = r_lu;
                    n_olr    = r_lr_s;
                    n_omd    = r_md;
                    n_omq    = r_mq;
                    n_obu    = r_bu;
                    n_olast  = 1'b1;
                    n_lost   = '0;
                    n_arr    = '0;
                    n_qws    = '0;
                    n_dws    = '0;
                    n_demand = 32'(r_buf);
                    n_wi     = '0;
                    n_run    = '0;
                    n_state  = (r_lr != '0) ? S_DW_RD : S_IDLE;
                end
            end
            S_DW_RD: begin
                w_raddr = w_walk;
                n_state = (r_wi == r_count) ? S_IDLE : S_DW_CALC;
            end
            S_DW_CALC: begin
                w_raddr = w_walk;
                n_run   = r_run + 27'(w_ramt);
                if (w_rdly == '0) begin
                    n_op    = prleq_pkg::OP_DLY;
                    n_state = S_OP;
                end else begin
                    n_wi    = r_wi + 1'b1;
                    n_state = S_DW_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= prleq_pkg::OP_STEP;
            r_bs     <= prleq_pkg::RST_BUFFER_SPACE;
            r_lr     <= prleq_pkg::RST_LINK_RATE;
            r_tu     <= prleq_pkg::RST_TARGET_UTIL;
            r_gain   <= prleq_pkg::RST_PRICE_GAIN;
            r_head   <= '0;
            r_count  <= '0;
            r_buf    <= '0;
            r_demand <= '0;
            r_price  <= prleq_pkg::PRICE_START;
            r_lost   <= '0;
            r_arr    <= '0;
            r_qws    <= '0;
            r_dws    <= '0;
            r_sent   <= '0;
            r_wi     <= '0;
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_head   <= n_head;
            r_count  <= n_count;
            r_buf    <= n_buf;
            r_demand <= n_demand;
            r_price  <= n_price;
            r_lost   <= n_lost;
            r_arr    <= n_arr;
            r_qws    <= n_qws;
            r_dws    <= n_dws;
            r_sent   <= n_sent;
            r_wi     <= n_wi;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) begin
                unique case (prleq_pkg::t_cfg_idx'(i_cfg_idx))
                    prleq_pkg::CFG_BUFFER_SPACE: r_bs   <= i_cfg_wdata;
                    prleq_pkg::CFG_LINK_RATE:    r_lr   <= i_cfg_wdata;
                    prleq_pkg::CFG_TARGET_UTIL:  r_tu   <= i_cfg_wdata[16:0];
                    prleq_pkg::CFG_PRICE_GAIN:   r_gain <= i_cfg_wdata[16:0];
                    default:                     r_bs   <= r_bs;
                endcase
            end
        end
        r_step   <= n_step;
        r_pq     <= n_pq;
        r_pd     <= n_pd;
        r_lu     <= n_lu;
        r_lr_s   <= n_lr_s;
        r_md     <= n_md;
        r_mq     <= n_mq;
        r_bu     <= n_bu;
        r_okind  <= n_okind;
        r_oamt   <= n_oamt;
        r_odrop  <= n_odrop;
        r_osdel  <= n_osdel;
        r_oprice <= n_oprice;
        r_olu    <= n_olu;
        r_olr    <= n_olr;
        r_omd    <= n_omd;
        r_omq    <= n_omq;
        r_obu    <= n_obu;
        r_olast  <= n_olast;
    end

    prleq_ram #(.WIDTH(24), .DEPTH(QUEUE_DEPTH)) u_ram_amt (
        .i_clk   (i_clk),
        .i_we    (w_we_amt),
        .i_waddr (w_waddr),
        .i_wdata (w_wamt),
        .i_raddr (w_raddr),
        .o_rdata (w_ramt)
    );

    prleq_ram #(.WIDTH(15), .DEPTH(QUEUE_DEPTH)) u_ram_qual (
        .i_clk   (i_clk),
        .i_we    (w_we_qual),
        .i_waddr (w_waddr),
        .i_wdata (w_in_qual),
        .i_raddr (w_raddr),
        .o_rdata (w_rqual)
    );

    prleq_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_ram_dly (
        .i_clk   (i_clk),
        .i_we    (w_we_dly),
        .i_waddr (w_waddr),
        .i_wdata (w_wdly),
        .i_raddr (w_raddr),
        .o_rdata (w_rdly)
    );

    prleq_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {r_obu, r_omq, r_omd, r_olr, r_olu, r_oprice,
                         r_osdel, r_odrop, r_oamt};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= DEPTH_C)
        else $error("entry count beyond queue depth");

    a_price_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_price >= prleq_pkg::PRICE_FLOOR)
        else $error("price below floor");

    a_segment_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == prleq_pkg::KIND_SEGMENT |-> !o_m_tlast)
        else $error("forwarded segment marked last");

    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DR_ACC |-> r_sent <= r_lr)
        else $error("drain exceeded link budget");

endmodule
`default_nettype wire

### tb/priced_rate_limited_egress_queue_test.sv
// self-checking testbench of the priced rate-limited egress queue
`default_nettype none
module priced_rate_limited_egress_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 6000;
    localparam int RANDOM_PER_PHASE = 29;

    typedef struct {
        prleq_pkg::t_cmd cmd;
        logic [23:0]     amt;
        logic [14:0]     qual;
        bit              hold;
    } t_packet;

    typedef struct {
        prleq_pkg::t_kind kind;
        logic [23:0] amount;
        logic [23:0] dropped;
        logic [31:0] seg_delay;
        logic [62:0] price;
        logic [16:0] link_use;
        logic [16:0] loss;
        logic [31:0] mean_delay;
        logic [14:0] mean_qual;
        logic [23:0] buf_use;
        logic        last;
    } t_egress;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [39:0]   i_s_tdata;
    logic          i_s_tuser;
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [247:0]  o_m_tdata;
    logic [1:0]    o_m_tuser;
    logic          o_m_tlast;
    logic          i_cfg_wen;
    logic [1:0]    i_cfg_idx;
    logic [23:0]   i_cfg_wdata;

    priced_rate_limited_egress_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // queue model state
    logic [23:0] buf_space, link_bw;
    logic [16:0] target_util, gain;
    logic [23:0] ent_amt [DEPTH];
    logic [14:0] ent_qual [DEPTH];
    logic [31:0] ent_delay [DEPTH];
    int unsigned head, count;
    logic [31:0] buffered, demand, lost, arrived;
    logic [63:0] price, qual_sum, delay_sum;

    t_packet pending [$];
    t_egress egress_due [$];
    t_packet cur;
    bit      fired;
    int      idle_s, idle_r;
    int      errors;
    int      cycles;

    function automatic logic [31:0] add_sat32(logic [31:0] x, logic [63:0] y);
        logic [64:0] s;
        s = x + y;
        return (s > 65'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function automatic logic [63:0] add_cap(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] cap);
        return (y > cap - x) ? cap : x + y;
    endfunction

    function automatic logic [63:0] mul_div(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] z);
        logic [127:0] q;
        q = ({64'd0, x} * {64'd0, y}) / {64'd0, z};
        return (q > {64'd0, {64{1'b1}}}) ? {64{1'b1}} : q[63:0];
    endfunction

    function automatic t_egress make_egress(prleq_pkg::t_kind k, logic [23:0] a,
                                            logic [23:0] d,
                                            logic [31:0] sd, logic [16:0] lu,
                                            logic [16:0] lr, logic [31:0] md,
                                            logic [14:0] mq, logic [23:0] bu,
                                            logic last);
        t_egress e;
        e.kind = k; e.amount = a; e.dropped = d; e.seg_delay = sd;
        e.price = price[62:0]; e.link_use = lu; e.loss = lr; e.mean_delay = md;
        e.mean_qual = mq; e.buf_use = bu; e.last = last;
        return e;
    endfunction

    task automatic reprice();
        logic [63:0] load, want, mag, step, delta, p;
        load = target_util * link_bw;
        want = {32'd0, demand} << 16;
        p = price;
        if (load != 0) begin
            mag = (want >= load) ? want - load : load - want;
            step = mul_div(p, gain, 64'd65536);
            delta = mul_div(step, mag, load);
            if (want >= load)
                p = (delta > {1'b0, prleq_pkg::PRICE_MAX} - p) ?
                    {1'b0, prleq_pkg::PRICE_MAX} : p + delta;
            else
                p = (delta >= p) ? 64'd0 : p - delta;
            if (p < {1'b0, prleq_pkg::PRICE_FLOOR})
                p = {1'b0, prleq_pkg::PRICE_FLOOR};
            price = p;
        end
    endtask

    task automatic predict_packet(t_packet it);
        logic [31:0] cap, take, drop, sent, part;
        logic [63:0] lu, lr, md, mq, bu, run, dv, d;
        bit push, whole;
        int unsigned t, h, e;
        if (it.cmd == prleq_pkg::CMD_ARRIVAL) begin
            cap = buf_space + link_bw;
            take = 0;
            drop = it.amt;
            push = 0;
            if (count >= DEPTH) begin
                drop = it.amt;
            end else if ({32'd0, buffered} + it.amt <= cap) begin
                take = it.amt; drop = 0; push = 1;
            end else if (buffered < cap) begin
                take = cap - buffered; drop = it.amt - take; push = 1;
            end
            if (push) begin
                t = (head + count) % DEPTH;
                ent_amt[t] = take[23:0];
                ent_qual[t] = it.qual;
                ent_delay[t] = 0;
                count++;
                buffered += take;
            end
            lost = add_sat32(lost, drop);
            qual_sum = add_cap(qual_sum, {32'd0, drop} * 4096, 64'hFFFFFFFFFFFF);
            demand = add_sat32(demand, it.amt);
            arrived = add_sat32(arrived, it.amt);
            egress_due = {egress_due, make_egress(prleq_pkg::KIND_VERDICT, take[23:0],
                                                  drop[23:0], 0, 0, 0, 0, 0, 0, 1'b1)};
        end else begin
            reprice();
            sent = 0;
            lu = 0; lr = 0; md = 0; mq = 0; bu = 0; run = 0;
            while (count > 0 && sent < link_bw) begin
                h = head;
                part = ent_amt[h];
                whole = ({32'd0, sent} + part) <= link_bw;
                if (!whole)
                    part = link_bw - sent;
                qual_sum = add_cap(qual_sum, {32'd0, part} * ent_qual[h],
                                   64'hFFFFFFFFFFFF);
                delay_sum = add_cap(delay_sum, {32'd0, part} * ent_delay[h],
                                    64'h3FFFFFFFFFFFFFF);
                buffered -= part;
                sent += part;
                egress_due = {egress_due, make_egress(prleq_pkg::KIND_SEGMENT, part[23:0],
                                                      0, ent_delay[h], 0, 0, 0, 0, 0,
                                                      1'b0)};
                if (whole) begin
                    head = (head + 1) % DEPTH;
                    count--;
                end else begin
                    ent_amt[h] -= part[23:0];
                end
            end
            if (link_bw != 0)
                lu = ({32'd0, sent} << 16) / link_bw;
            if (arrived != 0) begin
                lr = ({32'd0, lost} << 16) / arrived;
                if (lr > 65536)
                    lr = 65536;
                mq = qual_sum / arrived;
                if (mq > 64'h7FFF)
                    mq = 64'h7FFF;
            end
            if (arrived > lost) begin
                md = delay_sum / (arrived - lost);
                if (md > 64'hFFFFFFFF)
                    md = 64'hFFFFFFFF;
            end
            if (buf_space != 0) begin
                bu = ({32'd0, buffered} << 16) / buf_space;
                if (bu > 64'hFFFFFF)
                    bu = 64'hFFFFFF;
            end else if (buffered != 0) begin
                bu = 64'hFFFFFF;
            end
            egress_due = {egress_due, make_egress(prleq_pkg::KIND_SUMMARY, 0, 0, 0,
                                                  lu[16:0], lr[16:0], md[31:0],
                                                  mq[14:0], bu[23:0], 1'b1)};
            lost = 0; arrived = 0; qual_sum = 0; delay_sum = 0;
            if (link_bw != 0) begin
                dv = link_bw * 64'd10;
                for (int unsigned i = 0; i < count; i++) begin
                    e = (head + i) % DEPTH;
                    run += ent_amt[e];
                    if (ent_delay[e] == 0) begin
                        d = (run << 24) / dv;
                        ent_delay[e] = (d > 64'hFFFFFFFF) ? 32'hFFFFFFFF : d[31:0];
                    end
                end
            end
            demand = buffered;
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // input side: transfer sampled at the rising edge, next item at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            predict_packet(cur);
            fired = 1;
        end
    end

    always @(negedge i_clk) begin
        bit busy;
        busy = i_s_tvalid && !fired;
        fired = 0;
        if (i_rst_n && !busy) begin
            if (pending.size() > 0 && $urandom_range(0, 99) >= idle_s &&
                !(pending[0].hold && egress_due.size() != 0)) begin
                cur = pending[0];
                pending.delete(0);
                i_s_tdata <= {1'b0, cur.qual, cur.amt};
                i_s_tuser <= cur.cmd;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_tready <= ($urandom_range(0, 99) >= idle_r);
    end

    // output side
    always @(posedge i_clk) begin
        t_egress e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (egress_due.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = egress_due[0];
                egress_due.delete(0);
                check_field("result_kind", e.kind, o_m_tuser);
                check_field("amount", e.amount, o_m_tdata[23:0]);
                check_field("dropped_amount", e.dropped, o_m_tdata[47:24]);
                check_field("segment_delay", e.seg_delay, o_m_tdata[79:48]);
                check_field("price_now", e.price, o_m_tdata[142:80]);
                check_field("link_use", e.link_use, o_m_tdata[159:143]);
                check_field("loss_ratio", e.loss, o_m_tdata[176:160]);
                check_field("mean_delay", e.mean_delay, o_m_tdata[208:177]);
                check_field("mean_quality", e.mean_qual, o_m_tdata[223:209]);
                check_field("buffer_use", e.buf_use, o_m_tdata[247:224]);
                check_field("last_of_run", e.last, o_m_tlast);
            end
        end
    end

    task automatic write_reg(prleq_pkg::t_cfg_idx idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            prleq_pkg::CFG_BUFFER_SPACE: buf_space = val;
            prleq_pkg::CFG_LINK_RATE:    link_bw = val;
            prleq_pkg::CFG_TARGET_UTIL:  target_util = val[16:0];
            default:                     gain = val[16:0];
        endcase
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic configure(logic [23:0] bs, logic [23:0] lr, logic [16:0] tu,
                             logic [16:0] pg);
        write_reg(prleq_pkg::CFG_BUFFER_SPACE, bs);
        write_reg(prleq_pkg::CFG_LINK_RATE, lr);
        write_reg(prleq_pkg::CFG_TARGET_UTIL, {7'd0, tu});
        write_reg(prleq_pkg::CFG_PRICE_GAIN, {7'd0, pg});
    endtask

    task automatic queue_packet(prleq_pkg::t_cmd c, logic [23:0] a, logic [14:0] q,
                                bit hold);
        t_packet p;
        p.cmd = c; p.amt = a; p.qual = q; p.hold = hold;
        pending = {pending, p};
    endtask

    task automatic wait_quiet();
        while (pending.size() != 0 || i_s_tvalid || egress_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_random(int n, int tick_pct);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0)
                a = $urandom & 32'hFFFFFF;
            else
                a = $urandom_range(0, 2 * link_bw + 16);
            if (a > 32'hFFFFFF)
                a = 32'hFFFFFF;
            queue_packet(($urandom_range(0, 99) < tick_pct) ? prleq_pkg::CMD_TICK
                                                            : prleq_pkg::CMD_ARRIVAL,
                         a[23:0], 15'($urandom_range(0, 24576)),
                         ($urandom_range(0, 29) == 0));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = prleq_pkg::CFG_BUFFER_SPACE;
        i_cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        fired = 0;
        idle_s = 7;
        idle_r = 74;
        buf_space = prleq_pkg::RST_BUFFER_SPACE;
        link_bw = prleq_pkg::RST_LINK_RATE;
        target_util = prleq_pkg::RST_TARGET_UTIL;
        gain = prleq_pkg::RST_PRICE_GAIN;
        head = 0; count = 0;
        buffered = 0; demand = 0; lost = 0; arrived = 0;
        price = {1'b0, prleq_pkg::PRICE_START};
        qual_sum = 0; delay_sum = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, then a small buffer
        queue_packet(prleq_pkg::CMD_TICK, 24'd0, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd0, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd200, 15'd24576, 0);
        queue_packet(prleq_pkg::CMD_TICK, 24'hFFFFFF, 15'h7FFF, 0);
        wait_quiet();
        configure(24'd1024, 24'd256, 17'd58982, 17'd197);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd100, 15'd24576, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'hFFFFFF, 15'd12345, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd500, 15'd4096, 0);
        queue_packet(prleq_pkg::CMD_TICK, 24'd0, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_TICK, 24'd0, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd300, 15'h5555, 0);
        queue_packet(prleq_pkg::CMD_ARRIVAL, 24'd130, 15'h2AAA, 1);
        queue_packet(prleq_pkg::CMD_TICK, 24'h555555, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_TICK, 24'hAAAAAA, 15'd0, 0);
        queue_packet(prleq_pkg::CMD_TICK, 24'd0, 15'd0, 0);
        queue_random(RANDOM_PER_PHASE, 15);
        wait_quiet();

        // empty buffer space, widest link, full target and gain
        idle_s = 74;
        idle_r = 7;
        configure(24'd0, 24'hFFFFFF, 17'd65536, 17'd65536);
        queue_random(RANDOM_PER_PHASE, 8);
        wait_quiet();

        // huge buffer, slowest link, tiny target, no gain
        idle_s = 0;
        idle_r = 0;
        configure(24'hFFFFFF, 24'd1, 17'd1, 17'd0);
        queue_random(RANDOM_PER_PHASE, 5);
        wait_quiet();

        if (errors == 0 && egress_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
